[src/kdsbp_pkg.sv]
// ----------------------------------------------------------------------------
// kdsbp_pkg: shared types and constants of the k-d splitter bucket partition
// Operation codes and the fixed widths of the request, response and register
// fields.
// ----------------------------------------------------------------------------
package kdsbp_pkg;

   localparam int OP_BITS         = 3;
   localparam int NODE_BITS       = 6;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 4;
   localparam int DIM_BITS        = 4;
   localparam int NUM_COORDS      = 10;
   localparam int BUCKET_OUT_BITS = 6;
   localparam int POS_BITS        = 20;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD    = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_COUNT   = 3'd2,
      OP_FINISH  = 3'd3,
      OP_SCATTER = 3'd4
   } op_type;

endpackage

[src/kdsbp_ram.sv]
// ----------------------------------------------------------------------------
// kdsbp_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kdsbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[src/kdsbp_queue.sv]
// ----------------------------------------------------------------------------
// kdsbp_queue: short FIFO between the classifier and the counter unit
// Entries are flip-flops; the head is presented combinationally.
// ----------------------------------------------------------------------------
module kdsbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/kdsbp_front.sv]
// ----------------------------------------------------------------------------
// kdsbp_front: request intake and splitter-heap classifier
// Loads splitters, walks a point down the heap one level per cycle and hands
// the operation with its bucket to the counter unit through the queue.
// ----------------------------------------------------------------------------
module kdsbp_front #(
   parameter int LEVELS     = 6,
   parameter int MAX_DIMS   = 10,
   parameter int COORD_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kdsbp_pkg::OP_BITS-1:0]        req_operation,
   input  logic [kdsbp_pkg::NODE_BITS-1:0]      req_node_index,
   input  logic [COORD_BITS-1:0]                coords [kdsbp_pkg::NUM_COORDS],
   input  logic                                 csr_write_enable,
   input  logic [kdsbp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kdsbp_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                                 init_busy,
   input  logic                                 q_full,
   output logic                                 q_push,
   output logic [kdsbp_pkg::OP_BITS+LEVELS-1:0] q_push_data
);

   import kdsbp_pkg::*;

   localparam int BUCKETS  = 1 << LEVELS;
   localparam int LVL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int IDX_BITS = (NODE_BITS > LEVELS + 1) ? NODE_BITS : LEVELS + 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DIM = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_DIMS  = 1'd1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_WALK,
      F_PUSH
   } front_state_type;

   front_state_type         state_ff;
   logic [OP_BITS-1:0]      op_ff;
   logic [LEVELS-1:0]       k_ff;
   logic [LEVELS-1:0]       bkt_ff;
   logic [DIM_BITS-1:0]     d_ff;
   logic [LVL_BITS-1:0]     lvl_ff;
   logic [COORD_BITS-1:0]   coord_ff [NUM_COORDS];

   logic [DIM_BITS-1:0]     start_raw_ff;
   logic [DIM_BITS-1:0]     num_raw_ff;
   logic [DIM_BITS-1:0]     dim_work_ff;
   logic [DIM_BITS-1:0]     nd_eff;
   logic                    dim_busy;

   logic                    req_accept;
   logic                    is_point;
   logic                    load_ok;
   logic                    split_wr_en;
   logic [LEVELS-1:0]       split_rd_addr;
   logic [COORD_BITS-1:0]   split_rd_data;
   logic [COORD_BITS-1:0]   coord_sel;
   logic                    go_right;
   logic [LEVELS:0]         k_wide;
   logic [LEVELS-1:0]       k_next;
   logic [DIM_BITS-1:0]     d_next;

   // Effective dimension count: zero reads as one, large values clamp.
   always_comb begin
      if (num_raw_ff == '0) begin
         nd_eff = DIM_BITS'(1);
      end else if (num_raw_ff > DIM_BITS'(MAX_DIMS)) begin
         nd_eff = DIM_BITS'(MAX_DIMS);
      end else begin
         nd_eff = num_raw_ff;
      end
   end

   // The root dimension is reduced by repeated subtraction after a register
   // write; intake waits until it is below the dimension count.
   assign dim_busy = (dim_work_ff >= nd_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_raw_ff <= '0;
         num_raw_ff   <= DIM_BITS'(2);
         dim_work_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_START_DIM) begin
            start_raw_ff <= csr_write_data;
            dim_work_ff  <= csr_write_data;
         end else if (csr_index == CSR_NUM_DIMS) begin
            num_raw_ff  <= csr_write_data;
            dim_work_ff <= start_raw_ff;
         end
      end else if (dim_busy) begin
         dim_work_ff <= dim_work_ff - nd_eff;
      end
   end

   assign req_stall  = (state_ff != F_IDLE) || init_busy || dim_busy;
   assign req_accept = req_valid && !req_stall;
   assign is_point   = (req_operation == OP_COUNT) || (req_operation == OP_SCATTER);

   assign load_ok = (req_node_index != '0) &&
                    (IDX_BITS'(req_node_index) < IDX_BITS'(BUCKETS));
   assign split_wr_en = req_accept && (req_operation == OP_LOAD) && load_ok;

   // Heap walk: left child when the coordinate is below the splitter.
   assign coord_sel = coord_ff[d_ff];
   assign go_right  = !($signed(coord_sel) < $signed(split_rd_data));
   assign k_wide    = {k_ff, go_right};
   assign k_next    = k_wide[LEVELS-1:0];
   assign d_next    = (d_ff == nd_eff - 1'b1) ? '0 : d_ff + 1'b1;

   // The root is read while waiting so its value is ready on the first walk cycle.
   assign split_rd_addr = (state_ff == F_WALK) ? k_next : LEVELS'(1);

   kdsbp_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (BUCKETS)
   ) u_splitter_ram (
      .clock   (clock),
      .wr_en   (split_wr_en),
      .wr_addr (LEVELS'(req_node_index)),
      .wr_data (coords[0]),
      .rd_addr (split_rd_addr),
      .rd_data (split_rd_data)
   );

   assign q_push      = (state_ff == F_PUSH) && !q_full;
   assign q_push_data = {op_ff, bkt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_accept) begin
                  op_ff    <= req_operation;
                  coord_ff <= coords;
                  if (is_point) begin
                     k_ff     <= LEVELS'(1);
                     d_ff     <= dim_work_ff;
                     lvl_ff   <= '0;
                     state_ff <= F_WALK;
                  end else begin
                     bkt_ff   <= '0;
                     state_ff <= F_PUSH;
                  end
               end
            end
            F_WALK: begin
               k_ff   <= k_next;
               d_ff   <= d_next;
               lvl_ff <= lvl_ff + 1'b1;
               if (lvl_ff == LVL_BITS'(LEVELS - 1)) begin
                  bkt_ff   <= k_next;
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

[src/kdsbp_back.sv]
// ----------------------------------------------------------------------------
// kdsbp_back: bucket counter unit
// Counts and scatters points, clears the counters and turns counts into
// start offsets with a sweep; drives the response register.
// ----------------------------------------------------------------------------
module kdsbp_back #(
   parameter int LEVELS     = 6,
   parameter int COUNT_BITS = 21
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic [kdsbp_pkg::OP_BITS+LEVELS-1:0]  q_pop_data,
   output logic                                  init_busy,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [kdsbp_pkg::BUCKET_OUT_BITS-1:0] rsp_bucket,
   output logic [kdsbp_pkg::POS_BITS-1:0]        rsp_position,
   output logic                                  rsp_error
);

   import kdsbp_pkg::*;

   localparam int BUCKETS    = 1 << LEVELS;
   localparam int TOTAL_BITS = COUNT_BITS + LEVELS;
   localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
   localparam logic [TOTAL_BITS-1:0] COUNT_MAX_W = TOTAL_BITS'(COUNT_MAX);

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_POINT,
      B_FIN_SWEEP,
      B_FIN_DONE,
      B_CLEAR
   } back_state_type;

   back_state_type          state_ff;
   logic                    offsets_ready_ff;
   logic [LEVELS-1:0]       ptr_ff;
   logic [LEVELS-1:0]       bkt_ff;
   logic [TOTAL_BITS-1:0]   total_ff;

   logic                    rsp_valid_ff;
   logic [BUCKET_OUT_BITS-1:0] rsp_bucket_ff;
   logic [POS_BITS-1:0]     rsp_position_ff;
   logic                    rsp_error_ff;

   logic                    out_free;
   logic [OP_BITS-1:0]      q_op;
   logic [LEVELS-1:0]       q_bkt;
   logic                    phase_bad;

   logic                    cnt_wr_en;
   logic [LEVELS-1:0]       cnt_wr_addr;
   logic [COUNT_BITS-1:0]   cnt_wr_data;
   logic [LEVELS-1:0]       cnt_rd_addr;
   logic [COUNT_BITS-1:0]   cnt_rd_data;

   logic                    cnt_sat;
   logic [POS_BITS:0]       point_pos;
   logic                    tot_over;
   logic [COUNT_BITS-1:0]   tot_clamped;
   logic [POS_BITS:0]       fin_pos;

   // Returns {overflow, position} with the position clamped to its field.
   function automatic logic [POS_BITS:0] clamp_pos(input logic [COUNT_BITS-1:0] v);
      logic [CMP_BITS-1:0] wide;
      logic                over;
      wide = CMP_BITS'(v);
      over = (wide > CMP_BITS'(POS_MAX));
      return {over, (over ? POS_MAX : POS_BITS'(v))};
   endfunction

   assign {q_op, q_bkt} = q_pop_data;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty && out_free;
   assign init_busy = (state_ff == B_INIT);
   assign phase_bad = offsets_ready_ff != (q_op == OP_SCATTER);

   assign cnt_sat     = (cnt_rd_data == COUNT_MAX);
   assign point_pos   = clamp_pos(cnt_rd_data);
   assign tot_over    = (total_ff > COUNT_MAX_W);
   assign tot_clamped = tot_over ? COUNT_MAX : COUNT_BITS'(total_ff);
   assign fin_pos     = clamp_pos(tot_clamped);

   // The offset sweep reads one entry ahead of the one it writes.
   always_comb begin
      case (state_ff)
         B_FIN_SWEEP: cnt_rd_addr = ptr_ff + 1'b1;
         default:     cnt_rd_addr = (q_op == OP_FINISH) ? '0 : q_bkt;
      endcase
   end

   always_comb begin
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = ptr_ff;
      cnt_wr_data = '0;
      case (state_ff)
         B_INIT, B_CLEAR: begin
            cnt_wr_en = 1'b1;
         end
         B_FIN_SWEEP: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = tot_clamped;
         end
         B_POINT: begin
            cnt_wr_en   = !cnt_sat;
            cnt_wr_addr = bkt_ff;
            cnt_wr_data = cnt_rd_data + 1'b1;
         end
         default: begin
            cnt_wr_en = 1'b0;
         end
      endcase
   end

   kdsbp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BUCKETS)
   ) u_counter_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bucket   = rsp_bucket_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_error    = rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= B_INIT;
         ptr_ff           <= '0;
         offsets_ready_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // A pop decides the response register itself below.
         if (rsp_valid_ff && !rsp_stall && !q_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_INIT: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == '1) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_pop) begin
                  case (op_type'(q_op))
                     OP_COUNT, OP_SCATTER: begin
                        if (phase_bad) begin
                           rsp_valid_ff    <= 1'b1;
                           rsp_bucket_ff   <= BUCKET_OUT_BITS'(q_bkt);
                           rsp_position_ff <= '0;
                           rsp_error_ff    <= 1'b1;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           bkt_ff       <= q_bkt;
                           state_ff     <= B_POINT;
                        end
                     end
                     OP_FINISH: begin
                        if (offsets_ready_ff) begin
                           rsp_valid_ff    <= 1'b1;
                           rsp_bucket_ff   <= '0;
                           rsp_position_ff <= '0;
                           rsp_error_ff    <= 1'b1;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           ptr_ff       <= '0;
                           total_ff     <= '0;
                           state_ff     <= B_FIN_SWEEP;
                        end
                     end
                     OP_CLEAR: begin
                        rsp_valid_ff     <= 1'b0;
                        ptr_ff           <= '0;
                        offsets_ready_ff <= 1'b0;
                        state_ff         <= B_CLEAR;
                     end
                     default: begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_bucket_ff   <= '0;
                        rsp_position_ff <= '0;
                        rsp_error_ff    <= 1'b0;
                     end
                  endcase
               end
            end
            B_POINT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_bucket_ff   <= BUCKET_OUT_BITS'(bkt_ff);
               rsp_position_ff <= point_pos[POS_BITS-1:0];
               rsp_error_ff    <= cnt_sat || point_pos[POS_BITS];
               state_ff        <= B_IDLE;
            end
            B_FIN_SWEEP: begin
               total_ff <= total_ff + TOTAL_BITS'(cnt_rd_data);
               ptr_ff   <= ptr_ff + 1'b1;
               if (ptr_ff == '1) begin
                  state_ff <= B_FIN_DONE;
               end
            end
            B_FIN_DONE: begin
               rsp_valid_ff     <= 1'b1;
               rsp_bucket_ff    <= '0;
               rsp_position_ff  <= fin_pos[POS_BITS-1:0];
               rsp_error_ff     <= tot_over || fin_pos[POS_BITS];
               offsets_ready_ff <= 1'b1;
               state_ff         <= B_IDLE;
            end
            B_CLEAR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == '1) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_bucket_ff   <= '0;
                  rsp_position_ff <= '0;
                  rsp_error_ff    <= 1'b0;
                  state_ff        <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // No queue entry is taken before the counters are cleared after reset.
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INIT) |-> !q_pop)
      else $error("queue popped during counter initialization");

   // A completed offset sweep always leaves the block in the scatter phase.
   a_finish_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FIN_DONE) |=> offsets_ready_ff)
      else $error("offsets not marked ready after finish");

   // A counter update never wraps back to zero.
   a_count_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_POINT && cnt_wr_en) |-> (cnt_wr_data != '0))
      else $error("bucket counter wrapped");

endmodule

[src/kd_splitter_bucket_partition_core.sv]
// ----------------------------------------------------------------------------
// kd_splitter_bucket_partition_core: k-d splitter bucket partition
// Classifies points through a heap of splitters into 2^LEVELS buckets,
// counts them per bucket, forms start offsets and scatters points.
//
//   channel | ports                                 | transfer when
//   --------+---------------------------------------+----------------------
//   request | req_valid, req_stall, req_operation,  | req_valid && !req_stall
//           | req_node_index, req_coord_0..9        |
//   result  | rsp_valid, rsp_stall, rsp_bucket,     | rsp_valid && !rsp_stall
//           | rsp_position, rsp_error               |
//   config  | csr_write_enable, csr_index,          | csr_write_enable
//           | csr_write_data                        |
//
// After reset the counter RAM is cleared with intake held.
// A point passes the classifier's walk state (one splitter RAM read per heap
// level) and push state, then the counter unit's idle and point states; loads
// and other codes skip the walk. A finish sweeps the counter RAM and a clear
// zeroes it; a start_dim write holds intake while the root dimension is reduced.
// A two-entry queue and the response register keep intake going while a
// result is stalled.
// ----------------------------------------------------------------------------
module kd_splitter_bucket_partition_core #(
   parameter int LEVELS     = 6,
   parameter int MAX_DIMS   = 10,
   parameter int COUNT_BITS = 21,
   parameter int COORD_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [kdsbp_pkg::OP_BITS-1:0]         req_operation,
   input  logic [kdsbp_pkg::NODE_BITS-1:0]       req_node_index,
   input  logic signed [63:0]                    req_coord_0,
   input  logic signed [63:0]                    req_coord_1,
   input  logic signed [63:0]                    req_coord_2,
   input  logic signed [63:0]                    req_coord_3,
   input  logic signed [63:0]                    req_coord_4,
   input  logic signed [63:0]                    req_coord_5,
   input  logic signed [63:0]                    req_coord_6,
   input  logic signed [63:0]                    req_coord_7,
   input  logic signed [63:0]                    req_coord_8,
   input  logic signed [63:0]                    req_coord_9,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [kdsbp_pkg::BUCKET_OUT_BITS-1:0] rsp_bucket,
   output logic [kdsbp_pkg::POS_BITS-1:0]        rsp_position,
   output logic                                  rsp_error,
   input  logic                                  csr_write_enable,
   input  logic [kdsbp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kdsbp_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   import kdsbp_pkg::*;

   localparam int Q_WIDTH = OP_BITS + LEVELS;

   logic [COORD_BITS-1:0] coords [NUM_COORDS];
   logic                  q_push;
   logic [Q_WIDTH-1:0]    q_push_data;
   logic                  q_full;
   logic                  q_pop;
   logic [Q_WIDTH-1:0]    q_pop_data;
   logic                  q_empty;
   logic                  init_busy;

   assign coords[0] = req_coord_0[COORD_BITS-1:0];
   assign coords[1] = req_coord_1[COORD_BITS-1:0];
   assign coords[2] = req_coord_2[COORD_BITS-1:0];
   assign coords[3] = req_coord_3[COORD_BITS-1:0];
   assign coords[4] = req_coord_4[COORD_BITS-1:0];
   assign coords[5] = req_coord_5[COORD_BITS-1:0];
   assign coords[6] = req_coord_6[COORD_BITS-1:0];
   assign coords[7] = req_coord_7[COORD_BITS-1:0];
   assign coords[8] = req_coord_8[COORD_BITS-1:0];
   assign coords[9] = req_coord_9[COORD_BITS-1:0];

   kdsbp_front #(
      .LEVELS     (LEVELS),
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_node_index   (req_node_index),
      .coords           (coords),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .init_busy        (init_busy),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   kdsbp_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   kdsbp_back #(
      .LEVELS     (LEVELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_pop_data   (q_pop_data),
      .init_busy    (init_busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bucket   (rsp_bucket),
      .rsp_position (rsp_position),
      .rsp_error    (rsp_error)
   );

endmodule
